// ===== rtl/dlt_pkg.sv =====
// Shared types and constants of the decaying level table.
package dlt_pkg;

	// Field widths of the stream beats and the configuration port.
	localparam int CMD_BITS       = 3;
	localparam int INDEX_BITS     = 6;
	localparam int OPERAND_BITS   = 16;
	localparam int OUT_LEVEL_BITS = 16;
	localparam int S_TDATA_BITS   = 24;
	localparam int M_TDATA_BITS   = 24;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_MAX    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_STEP   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_ENABLE = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [CFG_DATA_BITS-1:0] LEVEL_MAX_RESET  = 16'd500;
	localparam logic [CFG_DATA_BITS-1:0] DECAY_STEP_RESET = 16'd1;

	// Command codes carried in s_tuser.
	typedef enum logic [CMD_BITS-1:0] {
		CMD_SET     = 3'd0,
		CMD_ADD     = 3'd1,
		CMD_SUB     = 3'd2,
		CMD_SET_ALL = 3'd3,
		CMD_ADD_ALL = 3'd4,
		CMD_SUB_ALL = 3'd5,
		CMD_TICK    = 3'd6
	} cmd_t;

	// Update applied to one entry.
	typedef enum logic [1:0] {
		OP_KEEP,
		OP_SET,
		OP_ADD,
		OP_SUB
	} op_t;

endpackage

// ===== rtl/dlt_level_unit.sv =====
// Per-entry level update: set, clamped add or floored subtract.
module dlt_level_unit
	import dlt_pkg::*;
#(
	parameter int LEVEL_BITS = 16
) (
	input  op_t                     op,
	input  logic [OPERAND_BITS-1:0] amount,
	input  logic [CFG_DATA_BITS-1:0] level_max,
	input  logic [LEVEL_BITS-1:0]   cur_level,
	output logic [LEVEL_BITS-1:0]   new_level
);

	localparam int WIDE_BITS = (LEVEL_BITS > OPERAND_BITS) ? LEVEL_BITS : OPERAND_BITS;
	localparam int SUM_BITS  = WIDE_BITS + 1;
	localparam logic [SUM_BITS-1:0] LEVEL_MASK = SUM_BITS'({LEVEL_BITS{1'b1}});

	logic [SUM_BITS-1:0] cur_w;
	logic [SUM_BITS-1:0] amt_w;
	logic [SUM_BITS-1:0] max_w;
	logic [SUM_BITS-1:0] sum_w;
	logic [SUM_BITS-1:0] clamp_w;

	assign cur_w = SUM_BITS'(cur_level);
	assign amt_w = SUM_BITS'(amount);
	assign max_w = SUM_BITS'(level_max);
	assign sum_w = cur_w + amt_w;

	// An add stops at level_max, even when the entry was set above it.
	assign clamp_w = (sum_w > max_w) ? max_w : sum_w;

	// Values beyond the entry width saturate to the largest storable level.
	always_comb begin
		case (op)
			OP_SET: begin
				new_level = (amt_w > LEVEL_MASK) ? LEVEL_BITS'(LEVEL_MASK) : LEVEL_BITS'(amt_w);
			end
			OP_ADD: begin
				new_level = (clamp_w > LEVEL_MASK) ? LEVEL_BITS'(LEVEL_MASK)
					: LEVEL_BITS'(clamp_w);
			end
			OP_SUB: begin
				new_level = (amt_w >= cur_w) ? '0 : LEVEL_BITS'(cur_w - amt_w);
			end
			default: begin
				new_level = cur_level;
			end
		endcase
	end

endmodule

// ===== rtl/decaying_level_table.sv =====
// Top level of the decaying level table: sequencer, level memory and stream ports.
// Single-entry commands, disabled ticks and the unused code read their entry on acceptance,
// compute the new level in ST_SINGLE and load the result beat in ST_DONE. Whole-table commands
// and enabled ticks sweep the memory one entry per cycle in ST_SWEEP, then go to ST_DONE.
// A result still waiting on m_tready holds the next item in its final state until it leaves.
// After reset s_tready stays low through a clearing pass over every entry; config writes go on.
module decaying_level_table
	import dlt_pkg::*;
#(
	parameter int ENTRIES    = 64,
	parameter int LEVEL_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [S_TDATA_BITS-1:0]   s_tdata,  // [5:0] entry_index, [21:6] operand_value
	input  logic [CMD_BITS-1:0]       s_tuser,  // [2:0] command
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [M_TDATA_BITS-1:0]   m_tdata   // [15:0] level, [16] level_is_zero
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [AW:0]   CNT_END   = (AW+1)'(ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SINGLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CFG_DATA_BITS-1:0] level_max_q;
	logic [CFG_DATA_BITS-1:0] decay_step_q;
	logic                     decay_enable_q;

	// Fields of the incoming beat.
	cmd_t                    in_cmd;
	logic [INDEX_BITS-1:0]   in_index;
	logic [OPERAND_BITS-1:0] in_operand;
	logic                    in_sweep;
	op_t                     in_op;
	logic [OPERAND_BITS-1:0] in_amount;
	logic                    in_valid_idx;

	// Item held while it is worked on.
	op_t                     op_q;
	logic [OPERAND_BITS-1:0] amount_q;
	logic [AW-1:0]           idx_addr_q;
	logic                    idx_valid_q;
	logic [LEVEL_BITS-1:0]   res_q;
	logic [AW:0]             cnt_q;

	// Memory ports and the read stage.
	logic [LEVEL_BITS-1:0] mem [ENTRIES];
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [LEVEL_BITS-1:0] rdata_s1;
	logic                  rd_valid_s1;
	logic [AW-1:0]         addr_s1;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [LEVEL_BITS-1:0] wr_data;
	logic [LEVEL_BITS-1:0] new_level;

	// Output register.
	logic                      m_tvalid_q;
	logic [OUT_LEVEL_BITS-1:0] out_level_q;
	logic                      out_zero_q;

	logic accept;
	logic out_free;
	logic sweep_issue;
	logic hit_s1;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_BITS - OUT_LEVEL_BITS - 1){1'b0}}, out_zero_q, out_level_q};

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_max_q    <= LEVEL_MAX_RESET;
			decay_step_q   <= DECAY_STEP_RESET;
			decay_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_LEVEL_MAX:    level_max_q    <= cfg_wdata;
				CFG_DECAY_STEP:   decay_step_q   <= cfg_wdata;
				CFG_DECAY_ENABLE: decay_enable_q <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	// Decode the command into an entry update and a sweep flag.
	assign in_cmd       = cmd_t'(s_tuser);
	assign in_index     = s_tdata[INDEX_BITS-1:0];
	assign in_operand   = s_tdata[INDEX_BITS +: OPERAND_BITS];
	assign in_valid_idx = (32'(in_index) < ENTRIES);

	always_comb begin
		in_sweep  = 1'b0;
		in_op     = OP_KEEP;
		in_amount = in_operand;
		case (in_cmd)
			CMD_SET:     in_op = OP_SET;
			CMD_ADD:     in_op = OP_ADD;
			CMD_SUB:     in_op = OP_SUB;
			CMD_SET_ALL: begin
				in_op    = OP_SET;
				in_sweep = 1'b1;
			end
			CMD_ADD_ALL: begin
				in_op    = OP_ADD;
				in_sweep = 1'b1;
			end
			CMD_SUB_ALL: begin
				in_op    = OP_SUB;
				in_sweep = 1'b1;
			end
			CMD_TICK: begin
				in_amount = decay_step_q;
				if (decay_enable_q) begin
					in_op    = OP_SUB;
					in_sweep = 1'b1;
				end
			end
			default: ;
		endcase
	end

	dlt_level_unit #(
		.LEVEL_BITS (LEVEL_BITS)
	) u_level (
		.op        (op_q),
		.amount    (amount_q),
		.level_max (level_max_q),
		.cur_level (rdata_s1),
		.new_level (new_level)
	);

	// Read and write port control. A sweep reads entry i+1 while it writes entry i,
	// and a single item writes only after its own read, so the ports never collide.
	assign sweep_issue = (state_q == ST_SWEEP) && (cnt_q != CNT_END);
	assign hit_s1      = rd_valid_s1 && idx_valid_q && (addr_s1 == idx_addr_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = new_level;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[AW-1:0];
				wr_data = '0;
			end
			ST_IDLE: begin
				if (accept && !in_sweep) begin
					rd_en   = 1'b1;
					rd_addr = AW'(in_index);
				end
			end
			ST_SINGLE: begin
				wr_en = idx_valid_q && (op_q != OP_KEEP);
			end
			ST_SWEEP: begin
				rd_en = sweep_issue;
				wr_en = rd_valid_s1;
			end
			default: ;
		endcase
	end

	// Level memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Sequencer with the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			// The final state reloads the valid itself when it hands over a result.
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q[AW-1:0] == LAST_ADDR) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + (AW+1)'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= in_sweep ? ST_SWEEP : ST_SINGLE;
					end
				end
				ST_SINGLE: begin
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					if (sweep_issue) begin
						cnt_q <= cnt_q + (AW+1)'(1);
					end
					if (rd_valid_s1 && (addr_s1 == LAST_ADDR)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload, the reported level and the output data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= rd_addr;
		end
		if (accept) begin
			op_q        <= in_op;
			amount_q    <= in_amount;
			idx_addr_q  <= AW'(in_index);
			idx_valid_q <= in_valid_idx;
			res_q       <= '0;
		end
		if ((state_q == ST_SINGLE) && idx_valid_q) begin
			res_q <= new_level;
		end
		if ((state_q == ST_SWEEP) && hit_s1) begin
			res_q <= new_level;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_level_q <= OUT_LEVEL_BITS'(res_q);
			out_zero_q  <= (res_q == '0);
		end
	end

endmodule

// ===== rtl/dlt_checker.sv =====
// Port-level assertions for the decaying level table, bound to its top level.
module dlt_checker
	import dlt_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [S_TDATA_BITS-1:0]   s_tdata,
	input logic [CMD_BITS-1:0]       s_tuser,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [M_TDATA_BITS-1:0]   m_tdata
);

	// A waiting input beat stays offered with the same contents.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input beat changed while waiting");

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its data.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// The zero flag agrees with the reported level.
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_LEVEL_BITS] == (m_tdata[OUT_LEVEL_BITS-1:0] == '0)))
		else $error("level_is_zero disagrees with level");

	// One item at a time: the block is busy right after it takes a beat.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

endmodule

bind decaying_level_table dlt_checker u_dlt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the decaying level table: stream driver, result monitor and shadow table.
`timescale 1ns / 1ps

module tb_top;
	import dlt_pkg::*;

	localparam int          N_ENTRIES    = 64;
	localparam int          LVL_BITS     = OUT_LEVEL_BITS;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          MAX_PRINTED  = 20;
	// Code 3'd7 has no command behind it; the block only reports the entry.
	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;

	// One command beat as it travels on the slave side.
	typedef struct packed {
		logic [CMD_BITS-1:0]     cmd;
		logic [INDEX_BITS-1:0]   idx;
		logic [OPERAND_BITS-1:0] operand;
	} table_op_t;

	// One reported level as it travels on the master side.
	typedef struct packed {
		logic [LVL_BITS-1:0] level;
		logic                is_zero;
	} level_report_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [S_TDATA_BITS-1:0]   s_tdata   = '0;  // [5:0] entry_index, [21:6] operand_value
	logic [CMD_BITS-1:0]       s_tuser   = '0;  // [2:0] command
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [M_TDATA_BITS-1:0]   m_tdata;         // [15:0] level, [16] level_is_zero

	// Shadow copy of the table and its registers.
	logic [LVL_BITS-1:0]      shadow_levels [N_ENTRIES];
	logic [CFG_DATA_BITS-1:0] level_ceiling = LEVEL_MAX_RESET;
	logic [CFG_DATA_BITS-1:0] decay_amount  = DECAY_STEP_RESET;
	logic                     decay_on      = 1'b0;

	table_op_t     op_queue [$];
	level_report_t expected_levels [$];
	int            error_count    = 0;
	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	logic          hold_req       = 1'b0;
	logic          hold_ack       = 1'b0;
	int            hold_left      = 0;
	int unsigned   cycle_count    = 0;

	decaying_level_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Clock with a 2 ns period.
	initial begin
		forever #1 clk = ~clk;
	end

	// Add with a ceiling at the level_max register.
	function automatic logic [LVL_BITS-1:0] clamped_sum(logic [LVL_BITS-1:0] cur,
			logic [OPERAND_BITS-1:0] amt);
		int unsigned total;
		total = int'(cur) + int'(amt);
		if (total > int'(level_ceiling)) begin
			total = int'(level_ceiling);
		end
		if (total > (2 ** LVL_BITS) - 1) begin
			total = (2 ** LVL_BITS) - 1;
		end
		return total[LVL_BITS-1:0];
	endfunction

	// Subtract that stops at zero.
	function automatic logic [LVL_BITS-1:0] floored_diff(logic [LVL_BITS-1:0] cur,
			logic [OPERAND_BITS-1:0] amt);
		return (amt >= cur) ? '0 : cur - amt;
	endfunction

	// Apply one command to the shadow table and return the addressed entry's level.
	function automatic level_report_t level_after(table_op_t op);
		level_report_t rep;
		bool_in_range_check: begin end
		case (op.cmd)
			CMD_SET: begin
				if (op.idx < N_ENTRIES) shadow_levels[op.idx] = op.operand;
			end
			CMD_ADD: begin
				if (op.idx < N_ENTRIES)
					shadow_levels[op.idx] = clamped_sum(shadow_levels[op.idx], op.operand);
			end
			CMD_SUB: begin
				if (op.idx < N_ENTRIES)
					shadow_levels[op.idx] = floored_diff(shadow_levels[op.idx], op.operand);
			end
			CMD_SET_ALL: begin
				for (int k = 0; k < N_ENTRIES; k++) shadow_levels[k] = op.operand;
			end
			CMD_ADD_ALL: begin
				for (int k = 0; k < N_ENTRIES; k++)
					shadow_levels[k] = clamped_sum(shadow_levels[k], op.operand);
			end
			CMD_SUB_ALL: begin
				for (int k = 0; k < N_ENTRIES; k++)
					shadow_levels[k] = floored_diff(shadow_levels[k], op.operand);
			end
			CMD_TICK: begin
				if (decay_on) begin
					for (int k = 0; k < N_ENTRIES; k++)
						shadow_levels[k] = floored_diff(shadow_levels[k], decay_amount);
				end
			end
			default: begin
			end
		endcase
		rep.level   = (op.idx < N_ENTRIES) ? shadow_levels[op.idx] : '0;
		rep.is_zero = (rep.level == '0);
		return rep;
	endfunction

	// Print one line for a mismatch, up to MAX_PRINTED of them, and count it.
	task automatic flag_mismatch(string msg);
		if (error_count < MAX_PRINTED) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
		error_count++;
	endtask

	function automatic void queue_op(logic [CMD_BITS-1:0] cmd, int idx, int opv);
		table_op_t op;
		op.cmd     = cmd;
		op.idx     = idx[INDEX_BITS-1:0];
		op.operand = opv[OPERAND_BITS-1:0];
		op_queue   = {op_queue, op};
	endfunction

	// Random command, biased toward a few hot entries and amounts that reach the ceiling.
	function automatic table_op_t random_op(int ceiling);
		table_op_t op;
		int        pick;
		int        span;
		pick = $urandom_range(99);
		if (pick < 22)      op.cmd = CMD_SET;
		else if (pick < 44) op.cmd = CMD_ADD;
		else if (pick < 64) op.cmd = CMD_SUB;
		else if (pick < 69) op.cmd = CMD_SET_ALL;
		else if (pick < 73) op.cmd = CMD_ADD_ALL;
		else if (pick < 78) op.cmd = CMD_SUB_ALL;
		else if (pick < 96) op.cmd = CMD_TICK;
		else                op.cmd = CMD_UNUSED;
		pick = $urandom_range(99);
		if (pick < 50)      op.idx = INDEX_BITS'($urandom_range(7));
		else if (pick < 55) op.idx = INDEX_BITS'(N_ENTRIES - 1);
		else                op.idx = INDEX_BITS'($urandom_range(N_ENTRIES - 1));
		span = (op.cmd == CMD_SET || op.cmd == CMD_SET_ALL) ? ceiling + 2 : ceiling / 3 + 3;
		if (span > 65535) span = 65535;
		pick = $urandom_range(99);
		if (pick < 8)       op.operand = '0;
		else if (pick < 14) op.operand = '1;
		else if (pick < 75) op.operand = OPERAND_BITS'($urandom_range(span));
		else                op.operand = OPERAND_BITS'($urandom());
		return op;
	endfunction

	// Slave-side driver: presents queued beats and predicts each accepted one.
	always @(posedge clk) begin
		table_op_t nxt;
		table_op_t taken;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				taken.cmd       = s_tuser;
				taken.idx       = s_tdata[INDEX_BITS-1:0];
				taken.operand   = s_tdata[INDEX_BITS +: OPERAND_BITS];
				expected_levels = {expected_levels, level_after(taken)};
			end
			if (!s_tvalid || s_tready) begin
				if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = op_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= S_TDATA_BITS'({nxt.operand, nxt.idx});
					s_tuser  <= nxt.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted down in cycles.
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Master-side monitor: stalls at random, holds off on request, checks each result beat.
	always @(posedge clk) begin
		level_report_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_levels.size() == 0) begin
					flag_mismatch($sformatf("result beat with nothing expected, tdata %h", m_tdata));
				end else begin
					want = expected_levels.pop_front();
					if (m_tdata[LVL_BITS-1:0] !== want.level)
						flag_mismatch($sformatf("level %0d, expected %0d",
							m_tdata[LVL_BITS-1:0], want.level));
					if (m_tdata[LVL_BITS] !== want.is_zero)
						flag_mismatch($sformatf("level_is_zero %b, expected %b",
							m_tdata[LVL_BITS], want.is_zero));
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Wait until every queued beat has gone in and every result has come back.
	task automatic drain();
		@(negedge clk);
		while (op_queue.size() != 0 || s_tvalid || expected_levels.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Write all three registers while the block is idle.
	task automatic program_table(int ceiling, int step, int enable);
		@(posedge clk);
		cfg_wr_en     <= 1'b1;
		cfg_index     <= CFG_LEVEL_MAX;
		cfg_wdata     <= ceiling[CFG_DATA_BITS-1:0];
		level_ceiling <= ceiling[CFG_DATA_BITS-1:0];
		@(posedge clk);
		cfg_index    <= CFG_DECAY_STEP;
		cfg_wdata    <= step[CFG_DATA_BITS-1:0];
		decay_amount <= step[CFG_DATA_BITS-1:0];
		@(posedge clk);
		cfg_index <= CFG_DECAY_ENABLE;
		cfg_wdata <= CFG_DATA_BITS'(enable[0]);
		decay_on  <= enable[0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Sequencer: reset, directed checks, back-pressure burst, then random phases.
	initial begin
		int ceiling;
		int step;
		int enable;
		for (int k = 0; k < N_ENTRIES; k++) shadow_levels[k] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: set above the ceiling, clamping add, floor at zero, frozen tick.
		queue_op(CMD_SET, 0, 0);
		queue_op(CMD_SET, 63, 16'hFFFF);
		queue_op(CMD_ADD, 63, 1);
		queue_op(CMD_ADD, 0, 16'hFFFF);
		queue_op(CMD_SUB, 0, 100);
		queue_op(CMD_SUB, 0, 16'hFFFF);
		queue_op(CMD_TICK, 63, 0);
		queue_op(CMD_SET_ALL, 21, 16'hAAAA);
		queue_op(CMD_ADD_ALL, 42, 16'h5555);
		queue_op(CMD_SUB_ALL, 1, 499);
		queue_op(CMD_UNUSED, 1, 0);
		queue_op(CMD_SET, 42, 16'h5555);
		queue_op(CMD_ADD, 5, 0);
		drain();

		// Widest ceiling with decay running.
		program_table(16'hFFFF, 1, 1);
		queue_op(CMD_TICK, 42, 0);
		queue_op(CMD_SET, 7, 16'hFFFF);
		queue_op(CMD_ADD, 7, 16'hFFFF);
		queue_op(CMD_ADD_ALL, 0, 16'hFFFF);
		drain();
		program_table(16'hFFFF, 16'hFFFF, 1);
		queue_op(CMD_TICK, 7, 0);
		drain();

		// Zero ceiling and zero decay step.
		program_table(0, 0, 1);
		queue_op(CMD_SET, 9, 3);
		queue_op(CMD_ADD, 9, 5);
		queue_op(CMD_TICK, 9, 0);
		queue_op(CMD_SUB_ALL, 9, 0);
		drain();

		// Receiver holds off while the sender keeps offering beats.
		program_table(int'(LEVEL_MAX_RESET), int'(DECAY_STEP_RESET), 1);
		hold_req = ~hold_req;
		for (int n = 0; n < 40; n++) op_queue = {op_queue, random_op(int'(LEVEL_MAX_RESET))};
		drain();

		// Random phases over several register settings and idling modes.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin ceiling = 500;                    step = 1;                    enable = 1; end
				1: begin ceiling = 65535;                  step = 65535;                enable = 1; end
				2: begin ceiling = 0;                      step = 0;                    enable = 0; end
				3: begin ceiling = $urandom_range(65535);  step = $urandom_range(50);   enable = 1; end
				4: begin ceiling = 1000;                   step = 7;                    enable = 1; end
				5: begin ceiling = $urandom_range(65535);  step = $urandom_range(65535);
					enable = $urandom_range(1); end
				6: begin ceiling = 65535;                  step = 0;                    enable = 1; end
				default: begin ceiling = $urandom_range(2000); step = $urandom_range(20);
					enable = 1; end
			endcase
			program_table(ceiling, step, enable);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			// The sender pauses halfway until all results are back.
			for (int n = 0; n < 120; n++) op_queue = {op_queue, random_op(ceiling)};
			drain();
			for (int n = 0; n < 120; n++) op_queue = {op_queue, random_op(ceiling)};
			drain();
		end

		// Let a late or stray beat show up before the verdict.
		repeat (N_ENTRIES + 8) @(posedge clk);
		if (expected_levels.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", expected_levels.size()));
		end
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
